[hdl/ir_code_macro_wake_matcher_defines.svh]
`ifndef IR_CODE_MACRO_WAKE_MATCHER_DEFINES_SVH
`define IR_CODE_MACRO_WAKE_MATCHER_DEFINES_SVH

// Concurrent check, sampled on the rising edge, off while reset is low
`define ACM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ACM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `ACM_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

[hdl/acm_pkg.sv]
package acm_pkg;

    // Table geometry
    localparam int MACRO_SLOT_COUNT = 8;
    localparam int MACRO_LENGTH     = 7;
    localparam int WAKE_SLOT_COUNT  = 8;

    localparam int SLOT_SPAN   = MACRO_LENGTH + 1;
    localparam int WAKE_BASE   = MACRO_SLOT_COUNT * SLOT_SPAN;
    localparam int TABLE_DEPTH = WAKE_BASE + WAKE_SLOT_COUNT;
    localparam int WAKE_SCAN   = WAKE_SLOT_COUNT / 2;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int MSLOT_W = (MACRO_SLOT_COUNT > 1) ? $clog2(MACRO_SLOT_COUNT) : 1;
    localparam int ENT_W   = $clog2(SLOT_SPAN);
    localparam int WSCAN_W = (WAKE_SCAN > 1) ? $clog2(WAKE_SCAN) : 1;

    // Code layout: bytes 0..4 payload, byte 5 flags
    localparam int CODE_W    = 48;
    localparam int FLAGS_LSB = 40;
    localparam int FLAGS_W   = CODE_W - FLAGS_LSB;

    // Stream field widths
    localparam int SLOT_IN_W = 3;
    localparam int POS_IN_W  = 3;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_code EMPTY_CODE = '1;

    typedef enum logic [1:0] {
        REQ_RECEIVE = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_READ    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_TRANSMIT = 2'd0,
        KIND_REPORT   = 2'd1,
        KIND_REPLY    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ADDR_LEARN  = 3'd0,
        ADDR_TRIG   = 3'd1,
        ADDR_ENTRY  = 3'd2,
        ADDR_WAKE   = 3'd3,
        ADDR_REBOOT = 3'd4,
        ADDR_ACCESS = 3'd5
    } t_addr_sel;

    typedef enum logic [1:0] {
        WSEL_MASKED = 2'd0,
        WSEL_CODE   = 2'd1,
        WSEL_EMPTY  = 2'd2
    } t_wr_sel;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      rd_en;
        logic      wr_en;
        t_wr_sel   wr_sel;
        t_addr_sel addr_sel;
        logic      mslot_clr;
        logic      mslot_inc;
        logic      ent_set;
        logic      ent_inc;
        logic      wk_clr;
        logic      wk_inc;
        logic      set_learned;
        logic      set_wake;
        logic      set_reboot;
        logic      emit;
        t_kind     kind;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_req req;
        logic repetition;
        logic host_awake;
        logic acc_err;
        logic rd_empty;
        logic rd_match;
        logic mslot_last;
        logic ent_last;
        logic wk_last;
        logic out_free;
    } t_dp_sts;

endpackage

[hdl/ir_code_macro_wake_matcher.sv]
// A received code runs a learn check of wake slot 0, a trigger scan of the macro slots,
// a read of the entries of each matching macro, a scan of the lower wake slots (skipped
// while the host is awake) and a compare with the last wake slot; a repeat frame goes
// straight to its report. A table access does one read or write (none on a range error).
// One item at a time, output stalls holding the run: next transfer taken once the final
// result is loaded. Each lookup on the single table port is a read state, then a check.
// Reset (synchronous, i_rst_n low): every table entry reads as empty, controller idles,
// output register empties.
module ir_code_macro_wake_matcher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // code[47:0], repetition[48], host_awake[49], region[50], slot[53:51], position[56:54]
    input  logic [acm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_code[47:0], wake[48], reboot[49], learned[50], error[51]
    output logic [acm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    acm_pkg::t_dp_cmd cmd;
    acm_pkg::t_dp_sts sts;

    // Sequencer
    acm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table, counters and output register
    acm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

[hdl/acm_dp.sv]
module acm_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  acm_pkg::t_dp_cmd                 i_cmd,
    output acm_pkg::t_dp_sts                 o_sts,
    input  logic [acm_pkg::S_TDATA_W-1:0]    i_in_data,
    input  logic [1:0]                       i_in_user,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [acm_pkg::M_TDATA_W-1:0]    o_out_data,
    output logic [1:0]                       o_out_user,
    output logic                             o_out_last
);

    // Latched request
    acm_pkg::t_req                      r_req;
    acm_pkg::t_code                     r_code;
    logic                               r_rep;
    logic                               r_awake;
    logic                               r_region;
    logic [acm_pkg::SLOT_IN_W-1:0]      r_slot_in;
    logic [acm_pkg::POS_IN_W-1:0]       r_pos_in;

    // Scan counters and run flags
    logic [acm_pkg::MSLOT_W-1:0]        r_mslot;
    logic [acm_pkg::ENT_W-1:0]          r_ent;
    logic [acm_pkg::WSCAN_W-1:0]        r_wk;
    logic                               r_learned;
    logic                               r_wake;
    logic                               r_reboot;

    // Table memory with per-entry valid bits
    acm_pkg::t_code                     mem [acm_pkg::TABLE_DEPTH];
    logic [acm_pkg::TABLE_DEPTH-1:0]    r_valid;
    acm_pkg::t_code                     r_rd_q;
    logic                               r_rd_vld;

    // Output register
    logic                               r_o_valid;
    acm_pkg::t_kind                     r_o_kind;
    acm_pkg::t_code                     r_o_code;
    logic                               r_o_wake;
    logic                               r_o_reboot;
    logic                               r_o_learned;
    logic                               r_o_error;
    logic                               r_o_last;

    acm_pkg::t_code                     masked;
    acm_pkg::t_code                     rd_data;
    acm_pkg::t_code                     wr_data;
    acm_pkg::t_addr                     addr;
    acm_pkg::t_addr                     acc_addr;
    acm_pkg::t_addr                     trig_addr;
    logic                               acc_err;

    // Received code with flags byte replaced by the repeat bit
    assign masked = {{(acm_pkg::FLAGS_W-1){1'b0}}, r_rep, r_code[acm_pkg::FLAGS_LSB-1:0]};

    // Entries never written read as empty
    assign rd_data = r_rd_vld ? r_rd_q : acm_pkg::EMPTY_CODE;

    // Host access range check and index
    always_comb begin
        if (!r_region) begin
            acc_err  = (32'(r_slot_in) >= acm_pkg::MACRO_SLOT_COUNT) ||
                       (32'(r_pos_in) > acm_pkg::MACRO_LENGTH);
            acc_addr = acm_pkg::ADDR_W'(32'(r_slot_in) * acm_pkg::SLOT_SPAN + 32'(r_pos_in));
        end else begin
            acc_err  = (32'(r_slot_in) >= acm_pkg::WAKE_SLOT_COUNT);
            acc_addr = acm_pkg::ADDR_W'(acm_pkg::WAKE_BASE + 32'(r_slot_in));
        end
    end

    assign trig_addr = acm_pkg::ADDR_W'(32'(r_mslot) * acm_pkg::SLOT_SPAN);

    // Table address select
    always_comb begin
        case (i_cmd.addr_sel)
            acm_pkg::ADDR_LEARN:  addr = acm_pkg::ADDR_W'(acm_pkg::WAKE_BASE);
            acm_pkg::ADDR_TRIG:   addr = trig_addr;
            acm_pkg::ADDR_ENTRY:  addr = trig_addr + acm_pkg::ADDR_W'(r_ent);
            acm_pkg::ADDR_WAKE:   addr = acm_pkg::ADDR_W'(acm_pkg::WAKE_BASE + 32'(r_wk));
            acm_pkg::ADDR_REBOOT: addr = acm_pkg::ADDR_W'(acm_pkg::TABLE_DEPTH - 1);
            acm_pkg::ADDR_ACCESS: addr = acc_addr;
            default:              addr = acc_addr;
        endcase
    end

    // Write data select
    always_comb begin
        case (i_cmd.wr_sel)
            acm_pkg::WSEL_MASKED: wr_data = masked;
            acm_pkg::WSEL_CODE:   wr_data = r_code;
            acm_pkg::WSEL_EMPTY:  wr_data = acm_pkg::EMPTY_CODE;
            default:              wr_data = acm_pkg::EMPTY_CODE;
        endcase
    end

    // Memory array, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_q <= mem[addr];
        end
    end

    // Valid bits: reset marks the whole table empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_valid[addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_valid[addr];
            end
        end
    end

    // Request capture on input transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= acm_pkg::t_req'(i_in_user);
            r_code    <= i_in_data[acm_pkg::CODE_W-1:0];
            r_rep     <= i_in_data[48];
            r_awake   <= i_in_data[49];
            r_region  <= i_in_data[50];
            r_slot_in <= i_in_data[53:51];
            r_pos_in  <= i_in_data[56:54];
        end
    end

    // Scan counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.mslot_clr) begin
            r_mslot <= '0;
        end else if (i_cmd.mslot_inc) begin
            r_mslot <= r_mslot + 1'b1;
        end
        if (i_cmd.ent_set) begin
            r_ent <= acm_pkg::ENT_W'(1);
        end else if (i_cmd.ent_inc) begin
            r_ent <= r_ent + 1'b1;
        end
        if (i_cmd.wk_clr) begin
            r_wk <= '0;
        end else if (i_cmd.wk_inc) begin
            r_wk <= r_wk + 1'b1;
        end
    end

    // Run flags, cleared for each new request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_learned <= 1'b0;
            r_wake    <= 1'b0;
            r_reboot  <= 1'b0;
        end else begin
            if (i_cmd.set_learned) r_learned <= 1'b1;
            if (i_cmd.set_wake)    r_wake    <= 1'b1;
            if (i_cmd.set_reboot)  r_reboot  <= 1'b1;
        end
    end

    // Output register: loaded on emit, freed on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind <= i_cmd.kind;
            case (i_cmd.kind)
                acm_pkg::KIND_TRANSMIT: begin
                    r_o_code    <= rd_data;
                    r_o_wake    <= 1'b0;
                    r_o_reboot  <= 1'b0;
                    r_o_learned <= 1'b0;
                    r_o_error   <= 1'b0;
                    r_o_last    <= 1'b0;
                end
                acm_pkg::KIND_REPORT: begin
                    r_o_code    <= masked;
                    r_o_wake    <= r_wake;
                    r_o_reboot  <= r_reboot;
                    r_o_learned <= r_learned;
                    r_o_error   <= 1'b0;
                    r_o_last    <= 1'b1;
                end
                default: begin
                    r_o_code    <= (r_req == acm_pkg::REQ_READ && !acc_err) ? rd_data : '0;
                    r_o_wake    <= 1'b0;
                    r_o_reboot  <= 1'b0;
                    r_o_learned <= 1'b0;
                    r_o_error   <= acc_err;
                    r_o_last    <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_user  = r_o_kind;
    assign o_out_last  = r_o_last;
    assign o_out_data  = {4'b0, r_o_error, r_o_learned, r_o_reboot, r_o_wake, r_o_code};

    // Status to the controller
    always_comb begin
        o_sts.req        = r_req;
        o_sts.repetition = r_rep;
        o_sts.host_awake = r_awake;
        o_sts.acc_err    = acc_err;
        o_sts.rd_empty   = (rd_data == acm_pkg::EMPTY_CODE);
        o_sts.rd_match   = (rd_data == masked);
        o_sts.mslot_last = (r_mslot == acm_pkg::MSLOT_W'(acm_pkg::MACRO_SLOT_COUNT - 1));
        o_sts.ent_last   = (r_ent == acm_pkg::ENT_W'(acm_pkg::MACRO_LENGTH));
        o_sts.wk_last    = (r_wk == acm_pkg::WSCAN_W'(acm_pkg::WAKE_SCAN - 1));
        o_sts.out_free   = !r_o_valid || i_out_ready;
    end

endmodule

[hdl/acm_ctrl.sv]
`include "ir_code_macro_wake_matcher_defines.svh"

module acm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  acm_pkg::t_dp_sts i_sts,
    output acm_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_DISP   = 15'b000000000000010,
        ST_LRN_RD = 15'b000000000000100,
        ST_LRN_CK = 15'b000000000001000,
        ST_TRG_RD = 15'b000000000010000,
        ST_TRG_CK = 15'b000000000100000,
        ST_ENT_RD = 15'b000000001000000,
        ST_ENT_CK = 15'b000000010000000,
        ST_WAK_RD = 15'b000000100000000,
        ST_WAK_CK = 15'b000001000000000,
        ST_RBT_RD = 15'b000010000000000,
        ST_RBT_CK = 15'b000100000000000,
        ST_REPORT = 15'b001000000000000,
        ST_ACC    = 15'b010000000000000,
        ST_REPLY  = 15'b100000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state wake_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // First state of the wake phase; wake scan skipped while host is up
    assign wake_entry = i_sts.host_awake ? ST_RBT_RD : ST_WAK_RD;

    // Sequencer
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = ST_DISP;
            end
            ST_DISP: begin
                if (i_sts.req != acm_pkg::REQ_RECEIVE) begin
                    n_state = ST_ACC;
                end else if (i_sts.repetition) begin
                    n_state = ST_REPORT;
                end else begin
                    n_state = ST_LRN_RD;
                end
            end
            // Learn into wake slot 0 when empty
            ST_LRN_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = acm_pkg::ADDR_LEARN;
                n_state        = ST_LRN_CK;
            end
            ST_LRN_CK: begin
                o_cmd.addr_sel  = acm_pkg::ADDR_LEARN;
                o_cmd.wr_sel    = acm_pkg::WSEL_MASKED;
                o_cmd.wr_en     = i_sts.rd_empty;
                o_cmd.set_learned = i_sts.rd_empty;
                o_cmd.mslot_clr = 1'b1;
                n_state         = ST_TRG_RD;
            end
            // Macro trigger scan
            ST_TRG_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = acm_pkg::ADDR_TRIG;
                n_state        = ST_TRG_CK;
            end
            ST_TRG_CK: begin
                if (i_sts.rd_empty) begin
                    o_cmd.wk_clr = 1'b1;
                    n_state      = wake_entry;
                end else if (i_sts.rd_match) begin
                    o_cmd.ent_set = 1'b1;
                    n_state       = ST_ENT_RD;
                end else if (i_sts.mslot_last) begin
                    o_cmd.wk_clr = 1'b1;
                    n_state      = wake_entry;
                end else begin
                    o_cmd.mslot_inc = 1'b1;
                    n_state         = ST_TRG_RD;
                end
            end
            // Macro body transmit
            ST_ENT_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = acm_pkg::ADDR_ENTRY;
                n_state        = ST_ENT_CK;
            end
            ST_ENT_CK: begin
                if (i_sts.rd_empty || (i_sts.out_free && i_sts.ent_last)) begin
                    o_cmd.emit = !i_sts.rd_empty;
                    o_cmd.kind = acm_pkg::KIND_TRANSMIT;
                    if (i_sts.mslot_last) begin
                        o_cmd.wk_clr = 1'b1;
                        n_state      = wake_entry;
                    end else begin
                        o_cmd.mslot_inc = 1'b1;
                        n_state         = ST_TRG_RD;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = acm_pkg::KIND_TRANSMIT;
                    o_cmd.ent_inc = 1'b1;
                    n_state       = ST_ENT_RD;
                end
            end
            // Lower wake slot scan
            ST_WAK_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = acm_pkg::ADDR_WAKE;
                n_state        = ST_WAK_CK;
            end
            ST_WAK_CK: begin
                if (i_sts.rd_empty) begin
                    n_state = ST_RBT_RD;
                end else begin
                    o_cmd.set_wake = i_sts.rd_match;
                    if (i_sts.wk_last) begin
                        n_state = ST_RBT_RD;
                    end else begin
                        o_cmd.wk_inc = 1'b1;
                        n_state      = ST_WAK_RD;
                    end
                end
            end
            // Last wake slot compare
            ST_RBT_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_sel = acm_pkg::ADDR_REBOOT;
                n_state        = ST_RBT_CK;
            end
            ST_RBT_CK: begin
                o_cmd.set_reboot = i_sts.rd_match;
                n_state          = ST_REPORT;
            end
            ST_REPORT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = acm_pkg::KIND_REPORT;
                    n_state    = ST_IDLE;
                end
            end
            // Host table access
            ST_ACC: begin
                o_cmd.addr_sel = acm_pkg::ADDR_ACCESS;
                o_cmd.wr_sel   = (i_sts.req == acm_pkg::REQ_WRITE) ? acm_pkg::WSEL_CODE
                                                                   : acm_pkg::WSEL_EMPTY;
                if (!i_sts.acc_err) begin
                    o_cmd.rd_en = (i_sts.req == acm_pkg::REQ_READ);
                    o_cmd.wr_en = (i_sts.req != acm_pkg::REQ_READ);
                end
                n_state = ST_REPLY;
            end
            ST_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = acm_pkg::KIND_REPLY;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Checks
    `ACM_ASSERT(a_emit_free, i_clk, i_rst_n, o_cmd.emit |-> i_sts.out_free, "emit while output busy")
    `ACM_ASSERT(a_rw_excl, i_clk, i_rst_n, o_cmd.wr_en |-> !o_cmd.rd_en, "table read and write together")
    `ACM_ASSERT_NEXT(a_rep_report, i_clk, i_rst_n, r_state == ST_DISP && i_sts.req == acm_pkg::REQ_RECEIVE && i_sts.repetition, r_state == ST_REPORT, "repeat frame ran table steps")
    `ACM_ASSERT_NEXT(a_final_idle, i_clk, i_rst_n, o_cmd.emit && o_cmd.kind != acm_pkg::KIND_TRANSMIT, r_state == ST_IDLE, "final item did not end the run")

endmodule
